>>> hw/rtl/atcm_pkg.sv
`timescale 1ns / 1ps
// Shared types and constants for the angle/target calibration map.
// Used by the channel interfaces, controller, datapath and top level.
package atcm_pkg;

  localparam int TABLE_DEPTH = 64;
  localparam int IDX_W       = $clog2(TABLE_DEPTH);
  localparam int CNT_W       = IDX_W + 1;
  localparam int ANG_W       = 16;
  localparam int TGT_W       = 12;
  localparam int OPW         = ANG_W + 1;          // signed operand width
  localparam int NUM_W       = 2 * ANG_W + 2;      // product magnitude width
  localparam int DCNT_W      = $clog2(NUM_W + 1);
  localparam int RES_W       = ANG_W + 4;          // signed result width

  localparam logic [TGT_W-1:0] TGT_MAX = 12'hfff;

  localparam logic [1:0] CFG_TABLE_ENABLE = 2'd0;
  localparam logic [1:0] CFG_MIN_ANGLE    = 2'd1;
  localparam logic [1:0] CFG_MAX_ANGLE    = 2'd2;

  localparam logic [ANG_W-1:0] MAX_ANGLE_RST = 16'd46080;

  typedef enum logic [1:0] {
    FN_CLEAR  = 2'd0,
    FN_APPEND = 2'd1,
    FN_A2T    = 2'd2,
    FN_T2A    = 2'd3
  } atcm_func_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_DECODE,
    ST_SCAN_RD,
    ST_SCAN_EV,
    ST_SETUP,
    ST_MUL,
    ST_DIV,
    ST_ROUND,
    ST_FINISH
  } atcm_state_t;

  typedef struct packed {
    logic capture;
    logic decode;
    logic scan_ev;
    logic setup;
    logic mul;
    logic div_step;
    logic round;
    logic load_out;
  } atcm_cmd_t;

  typedef struct packed {
    atcm_func_t func;
    logic       lut_ok;
    logic       oor;
    logic       scan_done;
    logic       div_done;
    logic       out_free;
  } atcm_sts_t;

endpackage

>>> hw/rtl/atcm_if.sv
`timescale 1ns / 1ps
// Valid/ready channel interfaces for requests and results.
// Depends on atcm_pkg for field widths.
interface atcm_in_if;
  logic                       valid;
  logic                       ready;
  logic [1:0]                 func;
  logic [atcm_pkg::ANG_W-1:0] angle_in;
  logic [atcm_pkg::TGT_W-1:0] target_in;
  logic                       use_table;
  modport source (output valid, func, angle_in, target_in, use_table, input ready);
  modport sink   (input valid, func, angle_in, target_in, use_table, output ready);
endinterface

interface atcm_out_if;
  logic                       valid;
  logic                       ready;
  logic [atcm_pkg::TGT_W-1:0] target_out;
  logic [atcm_pkg::ANG_W-1:0] angle_out;
  logic                       stop_motor;
  logic                       table_used;
  logic                       status;
  modport source (output valid, target_out, angle_out, stop_motor, table_used, status,
                  input ready);
  modport sink   (input valid, target_out, angle_out, stop_motor, table_used, status,
                  output ready);
endinterface

>>> hw/rtl/atcm_ctrl.sv
`timescale 1ns / 1ps
// Sequencer for the calibration map: decode, table scan, multiply, divide, round.
// Depends on atcm_pkg.
module atcm_ctrl (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_ready,
  input  atcm_pkg::atcm_sts_t sts,
  output atcm_pkg::atcm_cmd_t cmd
);
  import atcm_pkg::*;

  atcm_state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: begin
        if (in_valid) state_nxt = ST_DECODE;
      end
      ST_DECODE: begin
        case (sts.func)
          FN_CLEAR, FN_APPEND: state_nxt = ST_FINISH;
          FN_A2T: begin
            if (sts.oor) state_nxt = ST_FINISH;
            else if (sts.lut_ok) state_nxt = ST_SCAN_RD;
            else state_nxt = ST_SETUP;
          end
          default: begin
            state_nxt = sts.lut_ok ? ST_SCAN_RD : ST_SETUP;
          end
        endcase
      end
      ST_SCAN_RD: state_nxt = sts.scan_done ? ST_SETUP : ST_SCAN_EV;
      ST_SCAN_EV: state_nxt = ST_SCAN_RD;
      ST_SETUP:   state_nxt = ST_MUL;
      ST_MUL:     state_nxt = ST_DIV;
      ST_DIV: begin
        if (sts.div_done) state_nxt = ST_ROUND;
      end
      ST_ROUND:   state_nxt = ST_FINISH;
      ST_FINISH: begin
        if (sts.out_free) state_nxt = ST_IDLE;
      end
      default:    state_nxt = ST_IDLE;
    endcase
  end

  always_comb begin
    cmd      = '0;
    in_ready = 1'b0;
    case (state_r)
      ST_IDLE: begin
        in_ready    = 1'b1;
        cmd.capture = in_valid;
      end
      ST_DECODE:  cmd.decode   = 1'b1;
      ST_SCAN_EV: cmd.scan_ev  = 1'b1;
      ST_SETUP:   cmd.setup    = 1'b1;
      ST_MUL:     cmd.mul      = 1'b1;
      ST_DIV:     cmd.div_step = !sts.div_done;
      ST_ROUND:   cmd.round    = 1'b1;
      ST_FINISH:  cmd.load_out = sts.out_free;
      default: ;
    endcase
  end

endmodule

>>> hw/rtl/atcm_dp.sv
`timescale 1ns / 1ps
// Datapath: config registers, pair table memory, bracket scan, multiplier,
// bit-serial divider, rounding and result register. Depends on atcm_pkg.
module atcm_dp (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       cfg_we,
  input  logic [1:0]                 cfg_idx,
  input  logic [atcm_pkg::ANG_W-1:0] cfg_data,
  input  logic [1:0]                 req_func,
  input  logic [atcm_pkg::ANG_W-1:0] req_angle,
  input  logic [atcm_pkg::TGT_W-1:0] req_target,
  input  logic                       req_use_table,
  input  atcm_pkg::atcm_cmd_t        cmd,
  output atcm_pkg::atcm_sts_t        sts,
  output logic                       out_valid,
  input  logic                       out_ready,
  output logic [atcm_pkg::TGT_W-1:0] out_target,
  output logic [atcm_pkg::ANG_W-1:0] out_angle,
  output logic                       out_stop,
  output logic                       out_used,
  output logic                       out_status
);
  import atcm_pkg::*;

  // configuration
  logic             tbl_en_r;
  logic [ANG_W-1:0] min_r, max_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tbl_en_r <= 1'b0;
      min_r    <= '0;
      max_r    <= MAX_ANGLE_RST;
    end else if (cfg_we) begin
      case (cfg_idx)
        CFG_TABLE_ENABLE: tbl_en_r <= cfg_data[0];
        CFG_MIN_ANGLE:    min_r    <= cfg_data;
        CFG_MAX_ANGLE:    max_r    <= cfg_data;
        default: ;
      endcase
    end
  end

  // captured request
  atcm_func_t       func_r;
  logic [ANG_W-1:0] ang_r;
  logic [TGT_W-1:0] tgt_r;
  logic             use_r;

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      func_r <= atcm_func_t'(req_func);
      ang_r  <= req_angle;
      tgt_r  <= req_target;
      use_r  <= req_use_table;
    end
  end

  // pair table: {target, angle}
  logic [TGT_W+ANG_W-1:0] mem [TABLE_DEPTH];
  logic [TGT_W+ANG_W-1:0] rd_data_r;
  logic [CNT_W-1:0]       count_r;
  logic [CNT_W-1:0]       idx_r;
  logic                   full_r;
  logic                   full;

  assign full = (count_r == CNT_W'(TABLE_DEPTH));

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r <= '0;
    end else if (cmd.decode && func_r == FN_CLEAR) begin
      count_r <= '0;
    end else if (cmd.decode && func_r == FN_APPEND && !full) begin
      count_r <= count_r + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.decode && func_r == FN_APPEND && !full) begin
      mem[count_r[IDX_W-1:0]] <= {tgt_r, ang_r};
    end
    rd_data_r <= mem[idx_r[IDX_W-1:0]];
    if (cmd.decode) full_r <= full;
  end

  // bracket scan
  logic             by_angle;
  logic [ANG_W-1:0] x;
  logic [ANG_W-1:0] key, val;
  logic [ANG_W-1:0] k_lo_r, v_lo_r, k_hi_r, v_hi_r;
  logic             have_lo_r, have_hi_r;
  logic             lut_ok_r;

  assign by_angle = (func_r == FN_A2T);
  assign x        = by_angle ? ang_r : {{(ANG_W-TGT_W){1'b0}}, tgt_r};
  assign key = by_angle ? rd_data_r[ANG_W-1:0]
                        : {{(ANG_W-TGT_W){1'b0}}, rd_data_r[TGT_W+ANG_W-1:ANG_W]};
  assign val = by_angle ? {{(ANG_W-TGT_W){1'b0}}, rd_data_r[TGT_W+ANG_W-1:ANG_W]}
                        : rd_data_r[ANG_W-1:0];

  always_ff @(posedge clk) begin
    if (cmd.decode) begin
      idx_r     <= '0;
      have_lo_r <= 1'b0;
      have_hi_r <= 1'b0;
      lut_ok_r  <= use_r && tbl_en_r && (count_r != '0);
      k_lo_r    <= by_angle ? min_r : '0;
      v_lo_r    <= by_angle ? '0 : min_r;
      k_hi_r    <= by_angle ? max_r : {{(ANG_W-TGT_W){1'b0}}, TGT_MAX};
      v_hi_r    <= by_angle ? {{(ANG_W-TGT_W){1'b0}}, TGT_MAX} : max_r;
    end else if (cmd.scan_ev) begin
      idx_r <= idx_r + 1'b1;
      if (key <= x) begin
        k_lo_r    <= key;
        v_lo_r    <= val;
        have_lo_r <= 1'b1;
      end
      if (key >= x && !have_hi_r) begin
        k_hi_r    <= key;
        v_hi_r    <= val;
        have_hi_r <= 1'b1;
      end
    end
  end

  // operand select
  logic signed [OPW-1:0] a_r, b_r, d_r, base_r;
  logic signed [OPW-1:0] min_s, max_s;

  assign min_s = $signed({1'b0, min_r});
  assign max_s = $signed({1'b0, max_r});

  always_ff @(posedge clk) begin
    if (cmd.setup) begin
      if (lut_ok_r) begin
        a_r    <= $signed({1'b0, x}) - $signed({1'b0, k_lo_r});
        b_r    <= $signed({1'b0, v_hi_r}) - $signed({1'b0, v_lo_r});
        d_r    <= $signed({1'b0, k_hi_r}) - $signed({1'b0, k_lo_r});
        base_r <= $signed({1'b0, v_lo_r});
      end else if (by_angle) begin
        a_r    <= $signed({1'b0, ang_r}) - min_s;
        b_r    <= $signed({{(OPW-TGT_W){1'b0}}, TGT_MAX});
        d_r    <= max_s - min_s;
        base_r <= '0;
      end else begin
        a_r    <= $signed({{(OPW-TGT_W){1'b0}}, tgt_r});
        b_r    <= max_s - min_s;
        d_r    <= $signed({{(OPW-TGT_W){1'b0}}, TGT_MAX});
        base_r <= min_s;
      end
    end
  end

  // multiply magnitudes, then divide one quotient bit per cycle
  logic [OPW-1:0]    a_mag, b_mag;
  logic              neg_r;
  logic [NUM_W-1:0]  quo_r;
  logic [OPW-1:0]    rem_r;
  logic [DCNT_W-1:0] dcnt_r;
  logic [OPW:0]      rem_sh;
  logic [OPW:0]      d_ext;

  assign a_mag  = a_r[OPW-1] ? OPW'(-a_r) : OPW'(a_r);
  assign b_mag  = b_r[OPW-1] ? OPW'(-b_r) : OPW'(b_r);
  assign rem_sh = {rem_r, quo_r[NUM_W-1]};
  assign d_ext  = {1'b0, d_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      dcnt_r <= '0;
    end else if (cmd.mul) begin
      dcnt_r <= DCNT_W'(NUM_W);
    end else if (cmd.div_step) begin
      dcnt_r <= dcnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.mul) begin
      quo_r <= NUM_W'(a_mag * b_mag);
      rem_r <= '0;
      neg_r <= a_r[OPW-1] ^ b_r[OPW-1];
    end else if (cmd.div_step) begin
      if (rem_sh >= d_ext) begin
        rem_r <= OPW'(rem_sh - d_ext);
        quo_r <= {quo_r[NUM_W-2:0], 1'b1};
      end else begin
        rem_r <= rem_sh[OPW-1:0];
        quo_r <= {quo_r[NUM_W-2:0], 1'b0};
      end
    end
  end

  // round to nearest even, apply sign and base, clamp at zero
  logic [OPW:0]          rem2;
  logic                  up;
  logic [NUM_W-1:0]      qr;
  logic signed [RES_W-1:0] qv, res;
  logic [ANG_W-1:0]      res_r;

  assign rem2 = {rem_r, 1'b0};
  assign up   = (rem2 > d_ext) || (rem2 == d_ext && quo_r[0]);
  assign qr   = quo_r + NUM_W'(up);
  assign qv   = neg_r ? -$signed({2'b0, qr[RES_W-3:0]}) : $signed({2'b0, qr[RES_W-3:0]});
  assign res  = (d_r <= 0) ? RES_W'(base_r) : RES_W'(base_r) + qv;

  always_ff @(posedge clk) begin
    if (cmd.round) res_r <= res[RES_W-1] ? '0 : res[ANG_W-1:0];
  end

  // result register
  logic             out_valid_r;
  logic [TGT_W-1:0] out_target_r;
  logic [ANG_W-1:0] out_angle_r;
  logic             out_stop_r, out_used_r, out_status_r;
  logic             below, above, oor;

  assign below = ang_r < min_r;
  assign above = ang_r > max_r;
  assign oor   = below || above;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.load_out) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_out) begin
      out_target_r <= '0;
      out_angle_r  <= '0;
      out_stop_r   <= 1'b0;
      out_used_r   <= 1'b0;
      out_status_r <= 1'b0;
      case (func_r)
        FN_APPEND: out_status_r <= full_r;
        FN_A2T: begin
          if (oor) begin
            // below the range wins when min is above max
            out_target_r <= below ? '0 : TGT_MAX;
            out_stop_r   <= 1'b1;
          end else begin
            out_target_r <= res_r[TGT_W-1:0];
            out_used_r   <= lut_ok_r;
          end
        end
        FN_T2A: begin
          out_angle_r <= res_r;
          out_used_r  <= lut_ok_r;
        end
        default: ;
      endcase
    end
  end

  assign out_valid  = out_valid_r;
  assign out_target = out_target_r;
  assign out_angle  = out_angle_r;
  assign out_stop   = out_stop_r;
  assign out_used   = out_used_r;
  assign out_status = out_status_r;

  assign sts.func      = func_r;
  assign sts.lut_ok    = use_r && tbl_en_r && (count_r != '0);
  assign sts.oor       = oor;
  assign sts.scan_done = (idx_r == count_r) || (have_lo_r && have_hi_r);
  assign sts.div_done  = (dcnt_r == '0);
  assign sts.out_free  = !out_valid_r || out_ready;

endmodule

>>> hw/rtl/angle_target_calibration_map.sv
`timescale 1ns / 1ps
// Angle <-> 12-bit servo target map, linear or over a loaded pair table.
// Depends on atcm_pkg, atcm_if, atcm_ctrl and atcm_dp.
//
// One request at a time. Clear and append requests, and angle-to-target
// requests outside [min_angle, max_angle], skip the scan and arithmetic and go
// from decode straight to the result. Conversions pass through setup, multiply,
// divide and round, and, when the table is used, a bracket scan first: the scan
// alternates a read step and an evaluate step for each entry of the pair
// memory, and the 34-bit quotient comes from a restoring
// divider producing one bit per cycle.
// A finished result sits in an output register, so a new request can be
// accepted while it waits. Table contents are undefined until appended;
// clear only resets the entry count.
module angle_target_calibration_map (
  input  logic                       clk,
  input  logic                       rst_n,
  atcm_in_if.sink                    in_ch,
  atcm_out_if.source                 out_ch,
  input  logic                       cfg_we,
  input  logic [1:0]                 cfg_idx,
  input  logic [atcm_pkg::ANG_W-1:0] cfg_data
);
  import atcm_pkg::*;

  atcm_cmd_t cmd;
  atcm_sts_t sts;

  atcm_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_ch.valid),
    .in_ready (in_ch.ready),
    .sts      (sts),
    .cmd      (cmd)
  );

  atcm_dp u_dp (
    .clk           (clk),
    .rst_n         (rst_n),
    .cfg_we        (cfg_we),
    .cfg_idx       (cfg_idx),
    .cfg_data      (cfg_data),
    .req_func      (in_ch.func),
    .req_angle     (in_ch.angle_in),
    .req_target    (in_ch.target_in),
    .req_use_table (in_ch.use_table),
    .cmd           (cmd),
    .sts           (sts),
    .out_valid     (out_ch.valid),
    .out_ready     (out_ch.ready),
    .out_target    (out_ch.target_out),
    .out_angle     (out_ch.angle_out),
    .out_stop      (out_ch.stop_motor),
    .out_used      (out_ch.table_used),
    .out_status    (out_ch.status)
  );

endmodule
